[hw/rtl/read_quality_filter_assert.svh]
// Assertion macros shared by the read quality filter RTL.
`ifndef READ_QUALITY_FILTER_ASSERT_SVH
`define READ_QUALITY_FILTER_ASSERT_SVH

`ifndef SYNTHESIS

// Check a property on every clock edge outside reset.
`define RQF_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("read_quality_filter assertion failed");

// Check that a condition holds in the cycle after its trigger.
`define RQF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("read_quality_filter assertion failed");

`else

`define RQF_ASSERT(label, clk, rst, prop)
`define RQF_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[hw/rtl/rqf_pkg.sv]
// Shared constants, types and register codes of the read quality filter.
`default_nettype none

package rqf_pkg;

  localparam int MAX_READ_LEN = 1024;
  localparam int CNT_W        = $clog2(MAX_READ_LEN + 1);

  localparam int BASE_W   = 8;
  localparam int QUAL_W   = 8;
  localparam int NLIM_W   = 11;
  localparam int FRAC_W   = 17;
  localparam int WSTART_W = 10;
  localparam int WLEN_W   = 11;
  localparam int PASS_W   = 20;
  localparam int WEND_W   = WLEN_W + 1;
  localparam int PROD_W   = CNT_W + FRAC_W;
  localparam int BOUND_W  = PROD_W - 16;

  localparam logic [BASE_W-1:0] BASE_UNKNOWN   = 8'd78;
  localparam logic [FRAC_W-1:0] FRACTION_ONE   = 17'h10000;
  localparam logic [PASS_W-1:0] PASS_TOTAL_MAX = 20'hFFFFF;

  // Register bus
  localparam int DATA_W = 32;
  localparam int ADDR_W = 5;
  localparam int IDX_W  = 3;

  localparam logic [IDX_W-1:0] REG_N_LIMIT       = 3'd0;
  localparam logic [IDX_W-1:0] REG_QUALITY_THR   = 3'd1;
  localparam logic [IDX_W-1:0] REG_LOW_FRACTION  = 3'd2;
  localparam logic [IDX_W-1:0] REG_WINDOW_START  = 3'd3;
  localparam logic [IDX_W-1:0] REG_WINDOW_LENGTH = 3'd4;
  localparam logic [IDX_W-1:0] REG_MAX_PASSED    = 3'd5;

  // Queue sizes
  localparam int SUMQ_DEPTH = 4;
  localparam int SUMQ_AW    = $clog2(SUMQ_DEPTH);
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);

  typedef struct packed {
    logic [NLIM_W-1:0]   n_limit;
    logic [QUAL_W-1:0]   quality_threshold;
    logic [FRAC_W-1:0]   low_fraction;
    logic [WSTART_W-1:0] window_start;
    logic [WLEN_W-1:0]   window_length;
    logic [PASS_W-1:0]   max_passed;
  } cfg_t;

  typedef struct packed {
    logic [CNT_W-1:0] n_count;
    logic [CNT_W-1:0] low_count;
    logic [CNT_W-1:0] counted_length;
  } sum_t;

  typedef struct packed {
    logic             passed;
    logic [CNT_W-1:0] n_count;
    logic [CNT_W-1:0] low_count;
    logic [CNT_W-1:0] counted_length;
    logic             limit_reached;
  } res_t;

endpackage

`default_nettype wire

[hw/rtl/read_quality_filter.sv]
// Top level of the read quality filter: register port, front, summary queue, back.
//
//   channel   direction  handshake             payload
//   input     in         push / full           base, quality_char, last
//   result    out        pop / empty           passed, n_count, low_count,
//                                              counted_length, limit_reached
//   config    in/out     psel/penable/pwrite   paddr, pwdata, prdata (pready high)
//
// One base per cycle while full is low: the front only bumps running counters, and
// the back spends one 11x17 multiply per read, registered before the pass test.
// A result passes from the summary queue through the bound registers into the result
// queue before it shows on the result ports.
// Reset (rst, synchronous) clears counters, pass total, done and both queues, and
// loads the register defaults.
// full rises when four read summaries wait; the back takes one only when the
// result queue has room reserved for it, so results back up into the summary queue.
// Once done is set, bases are still taken but no further result is produced.
`default_nettype none

module read_quality_filter import rqf_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  // input requests
  input  wire logic                push,
  output logic                     full,
  input  wire logic [BASE_W-1:0]   base,
  input  wire logic [QUAL_W-1:0]   quality_char,
  input  wire logic                last,
  // result requests
  output logic                     empty,
  input  wire logic                pop,
  output logic                     passed,
  output logic [CNT_W-1:0]         n_count,
  output logic [CNT_W-1:0]         low_count,
  output logic [CNT_W-1:0]         counted_length,
  output logic                     limit_reached,
  // register port
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [ADDR_W-1:0]   paddr,
  input  wire logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]        prdata,
  output logic                     pready
);

  cfg_t             cfg;
  logic             cfg_wr;
  logic [IDX_W-1:0] reg_idx;
  logic             accept;
  logic             sum_push;
  sum_t             sum_wdata;
  logic             sum_empty;
  logic             sum_pop;
  sum_t             sum_rdata;
  res_t             res;

  // Register port: no wait states, write on the access phase
  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.n_limit           <= NLIM_W'(10);
      cfg.quality_threshold <= QUAL_W'(55);
      cfg.low_fraction      <= FRAC_W'(13107);
      cfg.window_start      <= '0;
      cfg.window_length     <= WLEN_W'(MAX_READ_LEN);
      cfg.max_passed        <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_N_LIMIT:       cfg.n_limit           <= pwdata[NLIM_W-1:0];
        REG_QUALITY_THR:   cfg.quality_threshold <= pwdata[QUAL_W-1:0];
        REG_LOW_FRACTION:  cfg.low_fraction      <= pwdata[FRAC_W-1:0];
        REG_WINDOW_START:  cfg.window_start      <= pwdata[WSTART_W-1:0];
        REG_WINDOW_LENGTH: cfg.window_length     <= pwdata[WLEN_W-1:0];
        REG_MAX_PASSED:    cfg.max_passed        <= pwdata[PASS_W-1:0];
        default: begin
          // unmapped address: drop the write
        end
      endcase
    end
  end

  // Read back the register value; unmapped addresses read zero
  always_comb begin
    unique case (reg_idx)
      REG_N_LIMIT:       prdata = DATA_W'(cfg.n_limit);
      REG_QUALITY_THR:   prdata = DATA_W'(cfg.quality_threshold);
      REG_LOW_FRACTION:  prdata = DATA_W'(cfg.low_fraction);
      REG_WINDOW_START:  prdata = DATA_W'(cfg.window_start);
      REG_WINDOW_LENGTH: prdata = DATA_W'(cfg.window_length);
      REG_MAX_PASSED:    prdata = DATA_W'(cfg.max_passed);
      default:           prdata = '0;
    endcase
  end

  // Hold off new bases only when the summary queue cannot take a read end
  assign accept = push && !full;

  rqf_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .accept       (accept),
    .base         (base),
    .quality_char (quality_char),
    .last         (last),
    .sum_push     (sum_push),
    .sum          (sum_wdata)
  );

  rqf_sum_fifo u_sum_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (sum_push),
    .wdata (sum_wdata),
    .full  (full),
    .pop   (sum_pop),
    .empty (sum_empty),
    .rdata (sum_rdata)
  );

  rqf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .sum_empty (sum_empty),
    .sum_rdata (sum_rdata),
    .sum_pop   (sum_pop),
    .res_pop   (pop),
    .res_empty (empty),
    .res       (res)
  );

  assign passed         = res.passed;
  assign n_count        = res.n_count;
  assign low_count      = res.low_count;
  assign counted_length = res.counted_length;
  assign limit_reached  = res.limit_reached;

endmodule

`default_nettype wire

[hw/rtl/rqf_front.sv]
// Per-base counting: window test, N and low-quality counts, one summary per read.
`default_nettype none
`include "read_quality_filter_assert.svh"

module rqf_front import rqf_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cfg_t              cfg,
  input  wire logic              accept,
  input  wire logic [BASE_W-1:0] base,
  input  wire logic [QUAL_W-1:0] quality_char,
  input  wire logic              last,
  output logic                   sum_push,
  output sum_t                   sum
);

  logic [CNT_W-1:0]  position;
  logic [CNT_W-1:0]  window_count;
  logic [CNT_W-1:0]  unknown_count;
  logic [CNT_W-1:0]  poor_count;
  logic [CNT_W-1:0]  position_next;
  logic [CNT_W-1:0]  window_count_next;
  logic [CNT_W-1:0]  unknown_count_next;
  logic [CNT_W-1:0]  poor_count_next;
  logic [WEND_W-1:0] win_end;
  logic              below_max;
  logic              in_window;

  assign win_end   = WEND_W'(cfg.window_start) + WEND_W'(cfg.window_length);
  assign below_max = position < CNT_W'(MAX_READ_LEN);
  assign in_window = below_max && (position >= CNT_W'(cfg.window_start)) &&
                     (WEND_W'(position) < win_end);

  always_comb begin
    window_count_next  = window_count;
    unknown_count_next = unknown_count;
    poor_count_next    = poor_count;
    position_next      = position;
    if (in_window) begin
      window_count_next = window_count + CNT_W'(1);
      if (base == BASE_UNKNOWN) begin
        unknown_count_next = unknown_count + CNT_W'(1);
      end
      if (quality_char < cfg.quality_threshold) begin
        poor_count_next = poor_count + CNT_W'(1);
      end
    end
    // Saturate at the longest read; later bases are never counted
    if (below_max) begin
      position_next = position + CNT_W'(1);
    end
  end

  assign sum_push           = accept && last;
  assign sum.n_count        = unknown_count_next;
  assign sum.low_count      = poor_count_next;
  assign sum.counted_length = window_count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      position      <= '0;
      window_count  <= '0;
      unknown_count <= '0;
      poor_count    <= '0;
    end else if (accept) begin
      if (last) begin
        position      <= '0;
        window_count  <= '0;
        unknown_count <= '0;
        poor_count    <= '0;
      end else begin
        position      <= position_next;
        window_count  <= window_count_next;
        unknown_count <= unknown_count_next;
        poor_count    <= poor_count_next;
      end
    end
  end

  `RQF_ASSERT(a_window_within_position, clk, rst, window_count <= position)
  `RQF_ASSERT(a_counts_within_window, clk, rst,
              (unknown_count <= window_count) && (poor_count <= window_count))
  `RQF_ASSERT_NEXT(a_last_clears, clk, rst, accept && last, position == '0)

endmodule

`default_nettype wire

[hw/rtl/rqf_sum_fifo.sv]
// Short queue of read summaries between the counting front and the decision back.
`default_nettype none

module rqf_sum_fifo import rqf_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire sum_t wdata,
  output logic      full,
  input  wire logic pop,
  output logic      empty,
  output sum_t      rdata
);

  sum_t               mem [SUMQ_DEPTH];
  logic [SUMQ_AW-1:0] wr_ptr;
  logic [SUMQ_AW-1:0] rd_ptr;
  logic [SUMQ_AW:0]   count;
  logic               do_push;
  logic               do_pop;

  assign full    = count == (SUMQ_AW + 1)'(SUMQ_DEPTH);
  assign empty   = count == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + SUMQ_AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + SUMQ_AW'(1);
      end
      count <= count + (SUMQ_AW + 1)'(do_push) - (SUMQ_AW + 1)'(do_pop);
    end
  end

endmodule

`default_nettype wire

[hw/rtl/rqf_back.sv]
// Read decision: quality bound multiply, pass test, pass total, done, result queue.
`default_nettype none
`include "read_quality_filter_assert.svh"

module rqf_back import rqf_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire cfg_t cfg,
  input  wire logic sum_empty,
  input  wire sum_t sum_rdata,
  output logic      sum_pop,
  input  wire logic res_pop,
  output logic      res_empty,
  output res_t      res
);

  // Bound stage
  logic               a_valid;
  sum_t               a_sum;
  logic [BOUND_W-1:0] a_bound;
  logic               a_n_ok;
  logic [FRAC_W-1:0]  frac;
  logic [PROD_W-1:0]  prod;

  // Decision and result queue
  logic [PASS_W-1:0]  pass_total;
  logic [PASS_W-1:0]  pass_total_next;
  logic               done;
  logic               pass;
  logic               reached;
  logic               out_wr;
  res_t               res_in;
  res_t               outq [OUTQ_DEPTH];
  logic [OUTQ_AW-1:0] out_wr_ptr;
  logic [OUTQ_AW-1:0] out_rd_ptr;
  logic [OUTQ_AW:0]   out_count;
  logic               out_rd;

  // Take a summary only with room reserved for it downstream
  assign sum_pop = !sum_empty &&
                   (((OUTQ_AW + 1)'(out_count) + (OUTQ_AW + 1)'(a_valid)) <
                    (OUTQ_AW + 1)'(OUTQ_DEPTH));

  assign frac = (cfg.low_fraction > FRACTION_ONE) ? FRACTION_ONE : cfg.low_fraction;
  assign prod = PROD_W'(sum_rdata.counted_length) * PROD_W'(frac);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= sum_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (sum_pop) begin
      a_sum   <= sum_rdata;
      a_bound <= prod[PROD_W-1:16];
      a_n_ok  <= sum_rdata.n_count < cfg.n_limit;
    end
  end

  assign pass   = a_n_ok && (BOUND_W'(a_sum.low_count) < a_bound);
  assign out_wr = a_valid && !done;

  always_comb begin
    pass_total_next = pass_total;
    if (out_wr && pass && (pass_total != PASS_TOTAL_MAX)) begin
      pass_total_next = pass_total + PASS_W'(1);
    end
  end

  assign reached = out_wr && pass && (cfg.max_passed != '0) &&
                   (pass_total_next >= cfg.max_passed);

  assign res_in.passed         = pass;
  assign res_in.n_count        = a_sum.n_count;
  assign res_in.low_count      = a_sum.low_count;
  assign res_in.counted_length = a_sum.counted_length;
  assign res_in.limit_reached  = reached;

  always_ff @(posedge clk) begin
    if (rst) begin
      pass_total <= '0;
      done       <= 1'b0;
    end else begin
      pass_total <= pass_total_next;
      if (reached) begin
        done <= 1'b1;
      end
    end
  end

  assign res_empty = out_count == '0;
  assign out_rd    = res_pop && !res_empty;
  assign res       = outq[out_rd_ptr];

  always_ff @(posedge clk) begin
    if (out_wr) begin
      outq[out_wr_ptr] <= res_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_wr_ptr <= '0;
      out_rd_ptr <= '0;
      out_count  <= '0;
    end else begin
      if (out_wr) begin
        out_wr_ptr <= out_wr_ptr + OUTQ_AW'(1);
      end
      if (out_rd) begin
        out_rd_ptr <= out_rd_ptr + OUTQ_AW'(1);
      end
      out_count <= out_count + (OUTQ_AW + 1)'(out_wr) - (OUTQ_AW + 1)'(out_rd);
    end
  end

  `RQF_ASSERT(a_credit_bound, clk, rst,
              ((OUTQ_AW + 1)'(out_count) + (OUTQ_AW + 1)'(a_valid)) <=
              (OUTQ_AW + 1)'(OUTQ_DEPTH))
  `RQF_ASSERT_NEXT(a_done_sticky, clk, rst, done, done)
  `RQF_ASSERT(a_no_result_after_done, clk, rst, done |-> !out_wr)
  `RQF_ASSERT(a_reach_needs_pass, clk, rst, reached |-> (pass && out_wr))

endmodule

`default_nettype wire
